// ===== hw/rtl/post_pkg.sv =====
package post_pkg;

	localparam int POINTS_DEF     = 48;
	localparam int GENERATORS_DEF = 8;
	localparam int CNT_W          = 4;
	localparam int NG_W           = CNT_W + 1;
	localparam int STEP_W         = 3;
	localparam int COND_W         = 3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
	localparam logic [STEP_W-1:0] ST_DEQ  = 3'd1;
	localparam logic [STEP_W-1:0] ST_CUR  = 3'd2;
	localparam logic [STEP_W-1:0] ST_VINV = 3'd3;
	localparam logic [STEP_W-1:0] ST_VFWD = 3'd4;
	localparam logic [STEP_W-1:0] ST_ORD  = 3'd5;
	localparam logic [STEP_W-1:0] ST_OWR  = 3'd6;

	localparam logic [COND_W-1:0] C_ALWAYS  = 3'd0;
	localparam logic [COND_W-1:0] C_START   = 3'd1;
	localparam logic [COND_W-1:0] C_QEMPTY  = 3'd2;
	localparam logic [COND_W-1:0] C_NOGEN   = 3'd3;
	localparam logic [COND_W-1:0] C_LASTGEN = 3'd4;
	localparam logic [COND_W-1:0] C_LASTPT  = 3'd5;

	typedef struct packed {
		logic       command;
		logic [2:0] gen_index;
		logic [5:0] point;
		logic [5:0] image;
	} req_t;

	typedef struct packed {
		logic [5:0] out_point;
		logic       in_orbit;
		logic       is_root;
		logic [2:0] via_gen;
		logic       via_inverse;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic              accept;
		logic              deq;
		logic              cur;
		logic              visit;
		logic              fwd;
		logic              out_read;
		logic              out_write;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] tgt_t;
		logic [STEP_W-1:0] tgt_f;
	} cw_t;

	// control store: next step is tgt_t when cond holds, else tgt_f
	function automatic cw_t ucode(input logic [STEP_W-1:0] step);
		cw_t w;
		w = '0;
		unique case (step)
			ST_IDLE: w = '{accept: 1'b1, cond: C_START, tgt_t: ST_DEQ, tgt_f: ST_IDLE,
				default: '0};
			ST_DEQ:  w = '{deq: 1'b1, cond: C_QEMPTY, tgt_t: ST_ORD, tgt_f: ST_CUR,
				default: '0};
			ST_CUR:  w = '{cur: 1'b1, cond: C_NOGEN, tgt_t: ST_DEQ, tgt_f: ST_VINV,
				default: '0};
			ST_VINV: w = '{visit: 1'b1, cond: C_ALWAYS, tgt_t: ST_VFWD, tgt_f: ST_VFWD,
				default: '0};
			ST_VFWD: w = '{visit: 1'b1, fwd: 1'b1, cond: C_LASTGEN, tgt_t: ST_DEQ,
				tgt_f: ST_VINV, default: '0};
			ST_ORD:  w = '{out_read: 1'b1, cond: C_ALWAYS, tgt_t: ST_OWR, tgt_f: ST_OWR,
				default: '0};
			ST_OWR:  w = '{out_write: 1'b1, cond: C_LASTPT, tgt_t: ST_IDLE, tgt_f: ST_ORD,
				default: '0};
			default: w = '{cond: C_ALWAYS, tgt_t: ST_IDLE, tgt_f: ST_IDLE, default: '0};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/permutation_orbit_schreier_tree.sv =====
// channel | signals                         | transaction
// req     | req_valid, req_ready, req       | load one table entry or start a search
// rsp     | rsp_valid, rsp_ready, rsp       | one tree entry, points in ascending order
// cfg     | cfg_valid, cfg_ready, cfg_data  | write generator_count
//
// a load leaves the sequencer idle, so req_ready stays high
// a start dequeues each reached point and visits its inverse and forward images for each of
// ng = min(generator_count, GENERATORS) generators, then reads out all POINTS entries; one visit per cycle,
// bounded by the single write port of the tree and queue memories
// reset clears the step counter, tree valid bits and queue pointers; tables need loads first
// a stalled result holds in the output register; the sequencer waits on it
module permutation_orbit_schreier_tree #(
	parameter int POINTS     = post_pkg::POINTS_DEF,
	parameter int GENERATORS = post_pkg::GENERATORS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  post_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output post_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [post_pkg::CNT_W-1:0] cfg_data
);

	localparam int PW  = $clog2(POINTS);
	localparam int PW1 = PW + 1;
	localparam int CW  = $clog2(POINTS + 1);
	localparam int TD  = GENERATORS * POINTS;
	localparam int AW  = $clog2(TD);
	localparam int NGW = post_pkg::NG_W;

	post_pkg::cw_t cw;

	logic [post_pkg::STEP_W-1:0] pc_q, pc_d;
	logic [post_pkg::CNT_W-1:0]  gen_count_q;
	logic [NGW-1:0]              ng, g_q;
	logic [AW-1:0]               addr_q, addr_nx, ld_addr_f, ld_addr_i, rd_addr;
	logic                        rd_en;

	logic [PW-1:0] fwd_mem [TD];
	logic [PW-1:0] inv_mem [TD];
	logic [PW-1:0] fwd_rd_q, inv_rd_q;

	logic [PW-1:0] q_mem [POINTS];
	logic [PW-1:0] q_rd_q, q_wa, q_wd;
	logic [CW-1:0] head_q, tail_q;

	logic [POINTS-1:0] valid_q;
	logic [3:0]        tree_mem [POINTS];
	logic [3:0]        tree_rd_q, tree_wd;
	logic [PW-1:0]     tree_wa;

	logic [PW-1:0] p_q;
	logic [5:0]    root_q;
	logic          rsp_valid_q;
	post_pkg::rsp_t rsp_q;

	logic acc, start, load, pt_ok, im_ok, gi_ok;
	logic q_empty, g_last, p_last, stall, take, mem_we;
	logic [PW-1:0] dest;
	logic dest_ok, is_new;

	assign cw        = post_pkg::ucode(pc_q);
	assign req_ready = cw.accept;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign acc   = req_valid & req_ready;
	assign pt_ok = 7'(req.point) < 7'(POINTS);
	assign im_ok = 7'(req.image) < 7'(POINTS);
	assign gi_ok = 5'(req.gen_index) < 5'(GENERATORS);
	assign start = acc & (req.command == post_pkg::CMD_START);
	assign load  = acc & (req.command == post_pkg::CMD_LOAD) & gi_ok & pt_ok & im_ok;

	assign ld_addr_f = AW'(req.gen_index) * AW'(POINTS) + AW'(req.point);
	assign ld_addr_i = AW'(req.gen_index) * AW'(POINTS) + AW'(req.image);
	assign addr_nx   = addr_q + AW'(POINTS);

	assign ng = ({1'b0, gen_count_q} > NGW'(GENERATORS)) ? NGW'(GENERATORS)
		: {1'b0, gen_count_q};

	assign q_empty = head_q == tail_q;
	assign g_last  = (g_q + NGW'(1)) == ng;
	assign p_last  = p_q == PW'(POINTS - 1);
	assign stall   = cw.out_write & rsp_valid_q & ~rsp_ready;

	assign dest    = cw.fwd ? fwd_rd_q : inv_rd_q;
	assign dest_ok = PW1'(dest) < PW1'(POINTS);
	assign is_new  = cw.visit & dest_ok & ~valid_q[dest];

	assign rd_en   = cw.cur | (cw.visit & cw.fwd & ~g_last);
	assign rd_addr = cw.cur ? AW'(q_rd_q) : addr_nx;

	assign mem_we  = (start & pt_ok) | is_new;
	assign q_wa    = start ? '0 : tail_q[PW-1:0];
	assign q_wd    = start ? PW'(req.point) : dest;
	assign tree_wa = start ? PW'(req.point) : dest;
	assign tree_wd = start ? 4'd0 : {g_q[2:0], cw.fwd};

	always_comb begin
		case (cw.cond)
			post_pkg::C_ALWAYS:  take = 1'b1;
			post_pkg::C_START:   take = start;
			post_pkg::C_QEMPTY:  take = q_empty;
			post_pkg::C_NOGEN:   take = ng == '0;
			post_pkg::C_LASTGEN: take = g_last;
			post_pkg::C_LASTPT:  take = p_last;
			default:             take = 1'b0;
		endcase
		pc_d = stall ? pc_q : (take ? cw.tgt_t : cw.tgt_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= post_pkg::ST_IDLE;
			gen_count_q <= post_pkg::CNT_W'(1);
			head_q      <= '0;
			tail_q      <= '0;
			valid_q     <= '0;
			g_q         <= '0;
			p_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (cfg_valid && cfg_ready) begin
				gen_count_q <= cfg_data;
			end
			if (start) begin
				head_q  <= '0;
				tail_q  <= pt_ok ? CW'(1) : '0;
				valid_q <= pt_ok ? (POINTS'(1) << req.point) : '0;
				p_q     <= '0;
			end
			if (cw.deq && !q_empty) begin
				head_q <= head_q + CW'(1);
			end
			if (cw.cur) begin
				g_q <= '0;
			end
			if (cw.visit && cw.fwd) begin
				g_q <= g_q + NGW'(1);
			end
			if (is_new) begin
				valid_q[dest] <= 1'b1;
				tail_q        <= tail_q + CW'(1);
			end
			if (cw.out_write && !stall) begin
				p_q         <= p_q + PW'(1);
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			root_q <= req.point;
		end
		if (cw.cur) begin
			addr_q <= AW'(q_rd_q);
		end else if (cw.visit && cw.fwd) begin
			addr_q <= addr_nx;
		end
		if (cw.out_write && !stall) begin
			rsp_q.out_point   <= 6'(p_q);
			rsp_q.in_orbit    <= valid_q[p_q];
			rsp_q.is_root     <= 6'(p_q) == root_q;
			rsp_q.via_gen     <= valid_q[p_q] ? tree_rd_q[3:1] : 3'd0;
			rsp_q.via_inverse <= valid_q[p_q] & tree_rd_q[0];
			rsp_q.last        <= p_last;
		end
	end

	// generator tables
	always_ff @(posedge clk) begin
		if (load) begin
			fwd_mem[ld_addr_f] <= PW'(req.image);
			inv_mem[ld_addr_i] <= PW'(req.point);
		end
		if (rd_en) begin
			fwd_rd_q <= fwd_mem[rd_addr];
			inv_rd_q <= inv_mem[rd_addr];
		end
	end

	// frontier queue
	always_ff @(posedge clk) begin
		if (mem_we) begin
			q_mem[q_wa] <= q_wd;
		end
		if (cw.deq) begin
			q_rd_q <= q_mem[head_q[PW-1:0]];
		end
	end

	// tree entries, masked by valid_q on read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[tree_wa] <= tree_wd;
		end
		if (cw.out_read) begin
			tree_rd_q <= tree_mem[p_q];
		end
	end

endmodule

// ===== hw/rtl/post_checker.sv =====
module post_checker #(
	parameter int POINTS = post_pkg::POINTS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input post_pkg::rsp_t rsp
);

	logic [5:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			exp_q <= rsp.last ? 6'd0 : rsp.out_point + 6'd1;
		end
	end

	// results of a run come in ascending point order from zero
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> rsp.out_point == exp_q)
		else $error("result point out of order");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.last == (rsp.out_point == 6'(POINTS - 1)))
		else $error("last flag on wrong point");

	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_root |-> rsp.in_orbit && rsp.via_gen == 3'd0 && !rsp.via_inverse)
		else $error("root entry malformed");

	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.in_orbit |-> rsp.via_gen == 3'd0 && !rsp.via_inverse && !rsp.is_root)
		else $error("unreached point carries tree data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind permutation_orbit_schreier_tree post_checker #(.POINTS(POINTS)) u_post_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int PTS     = post_pkg::POINTS_DEF;
	localparam int GENS    = post_pkg::GENERATORS_DEF;
	localparam int ITEMS   = 180;
	localparam int SETTLE  = 8;
	localparam int LIMIT   = 20000;

	class orbit_scoreboard;
		logic [5:0]     fwd_map [GENS*PTS];
		logic [5:0]     inv_map [GENS*PTS];
		bit             fwd_set [GENS*PTS];
		bit             inv_set [GENS*PTS];
		bit             reached [PTS];
		logic [2:0]     link_gen [PTS];
		bit             link_fwd [PTS];
		logic [3:0]     gen_count;
		post_pkg::rsp_t entries_due [$];
		int             mismatches;
		int             entries_checked;
		int             loads_done;
		int             searches_done;

		function new();
			gen_count = 4'd1;
		endfunction

		function void note_error(input string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: %s", $time, msg);
		endfunction

		function void set_count(input logic [3:0] v);
			gen_count = v;
		endfunction

		// breadth-first walk from root; returns 0 at the first table entry not yet written
		function bit grow_orbit(input logic [5:0] root, output bit hole_fwd,
				output int hole_gen, output int hole_pt);
			int fifo [$];
			int cur;
			int ng;
			int idx;
			int dest;
			ng = (gen_count > GENS) ? GENS : gen_count;
			hole_fwd = 1'b0;
			hole_gen = 0;
			hole_pt  = 0;
			foreach (reached[p]) begin
				reached[p]  = 1'b0;
				link_gen[p] = '0;
				link_fwd[p] = 1'b0;
			end
			if (root < PTS) begin
				reached[root] = 1'b1;
				fifo.insert(fifo.size(), int'(root));
			end
			while (fifo.size() != 0) begin
				cur = fifo.pop_front();
				for (int g = 0; g < ng; g++) begin
					idx = g * PTS + cur;
					for (int dir = 0; dir < 2; dir++) begin
						if ((dir == 0) ? !inv_set[idx] : !fwd_set[idx]) begin
							hole_fwd = (dir == 1);
							hole_gen = g;
							hole_pt  = cur;
							return 1'b0;
						end
						dest = (dir == 0) ? inv_map[idx] : fwd_map[idx];
						if (!reached[dest]) begin
							reached[dest]  = 1'b1;
							link_gen[dest] = 3'(g);
							link_fwd[dest] = (dir == 1);
							fifo.insert(fifo.size(), dest);
						end
					end
				end
			end
			return 1'b1;
		endfunction

		function void note_request(input post_pkg::req_t r);
			bit             hf;
			int             hg;
			int             hp;
			post_pkg::rsp_t e;
			if (r.command == post_pkg::CMD_LOAD) begin
				if (r.point < PTS && r.image < PTS) begin
					fwd_map[r.gen_index*PTS + r.point] = r.image;
					fwd_set[r.gen_index*PTS + r.point] = 1'b1;
					inv_map[r.gen_index*PTS + r.image] = r.point;
					inv_set[r.gen_index*PTS + r.image] = 1'b1;
					loads_done++;
				end
			end else begin
				if (!grow_orbit(r.point, hf, hg, hp))
					note_error($sformatf("search from %0d would read unwritten entry", r.point));
				for (int p = 0; p < PTS; p++) begin
					e.out_point   = 6'(p);
					e.in_orbit    = reached[p];
					e.is_root     = (p == r.point);
					e.via_gen     = link_gen[p];
					e.via_inverse = link_fwd[p];
					e.last        = (p == PTS - 1);
					entries_due.insert(entries_due.size(), e);
				end
				searches_done++;
			end
		endfunction

		function void check_result(input post_pkg::rsp_t got);
			post_pkg::rsp_t want;
			entries_checked++;
			if (entries_due.size() == 0) begin
				note_error($sformatf("unexpected tree entry for point %0d", got.out_point));
				return;
			end
			want = entries_due.pop_front();
			if (got.out_point !== want.out_point || got.in_orbit !== want.in_orbit ||
					got.is_root !== want.is_root || got.via_gen !== want.via_gen ||
					got.via_inverse !== want.via_inverse || got.last !== want.last)
				note_error($sformatf({"expected point %0d orbit %b root %b gen %0d inv %b last %b,",
					" got point %0d orbit %b root %b gen %0d inv %b last %b"},
					want.out_point, want.in_orbit, want.is_root, want.via_gen,
					want.via_inverse, want.last, got.out_point, got.in_orbit, got.is_root,
					got.via_gen, got.via_inverse, got.last));
		endfunction

		function void finish_check();
			if (entries_due.size() != 0)
				note_error($sformatf("%0d tree entries never arrived", entries_due.size()));
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_ready;
	post_pkg::req_t             req       = '0;
	logic                       rsp_valid;
	logic                       rsp_ready = 1'b0;
	post_pkg::rsp_t             rsp;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [post_pkg::CNT_W-1:0] cfg_data  = '0;

	orbit_scoreboard sb = new();

	int items_sent;
	int burst_left;
	int cfg_writes;
	int stall_mode;
	int stall_left;
	int idle_cycles;

	permutation_orbit_schreier_tree DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result monitor, receiver stall pattern and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(10, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			default: rsp_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_item(input post_pkg::req_t item);
		int gap;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(item);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_entry(input int g, input int p, input int q);
		post_pkg::req_t item;
		item.command   = post_pkg::CMD_LOAD;
		item.gen_index = 3'(g);
		item.point     = 6'(p);
		item.image     = 6'(q);
		send_item(item);
	endtask

	// fill every entry the search will read, with images kept inside the window
	task automatic run_search(input logic [5:0] root, input int lo, input int width);
		bit             hf;
		int             hg;
		int             hp;
		post_pkg::req_t item;
		while (!sb.grow_orbit(root, hf, hg, hp)) begin
			if (hf)
				load_entry(hg, hp, lo + $urandom_range(0, width - 1));
			else
				load_entry(hg, lo + $urandom_range(0, width - 1), hp);
		end
		item.command   = post_pkg::CMD_START;
		item.gen_index = 3'($urandom);
		item.point     = root;
		item.image     = 6'($urandom);
		send_item(item);
	endtask

	task automatic write_count(input logic [3:0] v);
		req_valid <= 1'b0;
		while (sb.entries_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_count(v);
		cfg_writes++;
	endtask

	initial begin
		int          phase;
		int          ng;
		int          width;
		int          lo;
		logic [3:0]  v;
		logic [5:0]  root;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two-point swap, self loops, ignored loads, out-of-range starts
		load_entry(0, 0, 47);
		load_entry(0, 47, 0);
		load_entry(7, 47, 47);
		load_entry(3, 63, 5);
		load_entry(5, 5, 63);
		load_entry(2, 48, 48);
		run_search(6'd0, 0, 48);
		run_search(6'd47, 0, 48);
		run_search(6'd63, 0, 48);
		run_search(6'd48, 0, 48);
		write_count(4'd0);
		run_search(6'd5, 5, 1);
		run_search(6'd0, 0, 1);

		phase = 0;
		while (items_sent < ITEMS) begin
			case (phase)
				0: v = 4'd15;
				1: v = 4'd8;
				2: v = 4'd1;
				default: v = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
					4'($urandom_range(1, 3));
			endcase
			write_count(v);
			ng = (v > GENS) ? GENS : v;
			repeat ($urandom_range(1, 3)) begin
				if (items_sent < ITEMS) begin
					width = (ng <= 1) ? $urandom_range(2, 16) :
						(ng <= 3) ? $urandom_range(2, 6) : $urandom_range(1, 3);
					lo = $urandom_range(0, PTS - width);
					repeat ($urandom_range(0, 4)) begin
						if ($urandom_range(0, 4) == 0)
							load_entry($urandom_range(0, 7), $urandom_range(0, 63),
								$urandom_range(0, 63));
						else
							load_entry($urandom_range(0, 7), lo + $urandom_range(0, width - 1),
								lo + $urandom_range(0, width - 1));
					end
					root = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(PTS, 63)) :
						6'(lo + $urandom_range(0, width - 1));
					run_search(root, lo, width);
				end
			end
			phase++;
		end

		req_valid <= 1'b0;
		while (sb.entries_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		sb.finish_check();
		$display("run covered %0d table loads and %0d orbit searches over %0d count settings",
			sb.loads_done, sb.searches_done, cfg_writes);
		$display("%0d tree entries checked, %0d mismatches", sb.entries_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
